/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/bfha_pkg.sv */
package bfha_pkg;

    // Default sizes of the descriptor table and the two sorted lists.
    localparam int DEF_DESCRIPTORS  = 64;
    localparam int DEF_FREE_ENTRIES = 32;
    localparam int DEF_USED_ENTRIES = 32;

    // Sorted list operations.
    localparam logic [2:0] LIST_NONE      = 3'd0;
    localparam logic [2:0] LIST_FIND_KEY  = 3'd1;
    localparam logic [2:0] LIST_FIND_SLOT = 3'd2;
    localparam logic [2:0] LIST_INSERT    = 3'd3;
    localparam logic [2:0] LIST_REMOVE    = 3'd4;
    localparam logic [2:0] LIST_INIT_ONE  = 3'd5;
    localparam logic [2:0] LIST_CLEAR     = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] key;
    } list_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } list_resp_t;

endpackage

/* sv/bfha_sorted_list.sv */
module bfha_sorted_list import bfha_pkg::*; #(
    parameter int DEPTH = DEF_FREE_ENTRIES,
    parameter int SW = 6,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  list_cmd_t       cmd,
    input  logic [SW-1:0]   cmd_slot,
    input  logic [CW-1:0]   cmd_pos,
    output list_resp_t      resp,
    output logic [CW-1:0]   resp_pos,
    output logic [15:0]     resp_key,
    output logic [SW-1:0]   resp_slot
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = 16 + SW;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SCAN = 3'd1;
    localparam logic [2:0] L_PREP = 3'd2;
    localparam logic [2:0] L_SHUP = 3'd3;
    localparam logic [2:0] L_SHDN = 3'd4;
    localparam logic [2:0] L_PUT  = 3'd5;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;
    logic [EW-1:0] wdata;
    logic [IW-1:0] raddr, waddr;
    logic          we;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [15:0]   key_reg, key_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    logic [15:0]   hkey_reg, hkey_next;
    logic [SW-1:0] hslot_reg, hslot_next;

    logic [CW-1:0] k_inc, k_dec, cnt_dec, pos_inc;
    logic [15:0]   e_key;
    logic [SW-1:0] e_slot;
    logic          match;

    assign k_inc   = k_reg + CW'(1);
    assign k_dec   = k_reg - CW'(1);
    assign cnt_dec = count_reg - CW'(1);
    assign pos_inc = pos_reg + CW'(1);
    assign e_key   = rdata_reg[EW-1:SW];
    assign e_slot  = rdata_reg[SW-1:0];
    assign match   = (op_reg == LIST_FIND_SLOT) ? (e_slot == slot_reg) : (e_key >= key_reg);

    assign resp      = '{done: done_reg, found: found_reg, full: (count_reg == CW'(DEPTH))};
    assign resp_pos  = pos_reg;
    assign resp_key  = hkey_reg;
    assign resp_slot = hslot_reg;

    // Sequencer: linear scan, shift up for insert, shift down for remove; init and clear act directly from idle.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        hkey_next  = hkey_reg;
        hslot_next = hslot_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = {key_reg, slot_reg};
        raddr      = k_inc[IW-1:0];
        case (state_reg)
            L_IDLE: begin
                raddr = '0;
                case (cmd.op)
                    LIST_INIT_ONE: begin
                        we         = 1'b1;
                        wdata      = {cmd.key, cmd_slot};
                        count_next = CW'(1);
                        done_next  = 1'b1;
                    end
                    LIST_CLEAR: begin
                        count_next = '0;
                        done_next  = 1'b1;
                    end
                    LIST_FIND_KEY, LIST_FIND_SLOT, LIST_INSERT: begin
                        op_next   = cmd.op;
                        key_next  = cmd.key;
                        slot_next = cmd_slot;
                        k_next    = '0;
                        if (cmd.op == LIST_INSERT && count_reg == CW'(DEPTH)) begin
                            done_next  = 1'b1;
                            found_next = 1'b0;
                        end else if (count_reg == '0) begin
                            pos_next = '0;
                            if (cmd.op == LIST_INSERT) begin
                                state_next = L_PUT;
                            end else begin
                                done_next  = 1'b1;
                                found_next = 1'b0;
                            end
                        end else begin
                            state_next = L_SCAN;
                        end
                    end
                    LIST_REMOVE: begin
                        op_next    = cmd.op;
                        pos_next   = cmd_pos;
                        state_next = L_PREP;
                    end
                    default: ;
                endcase
            end
            L_SCAN: begin
                if (match || k_reg == cnt_dec) begin
                    pos_next   = match ? k_reg : count_reg;
                    hkey_next  = e_key;
                    hslot_next = e_slot;
                    found_next = match;
                    if (op_reg == LIST_INSERT) begin
                        state_next = L_PREP;
                    end else begin
                        done_next  = 1'b1;
                        state_next = L_IDLE;
                    end
                end else begin
                    k_next = k_inc;
                end
            end
            L_PREP: begin
                if (op_reg == LIST_INSERT) begin
                    if (pos_reg == count_reg) begin
                        state_next = L_PUT;
                    end else begin
                        raddr      = cnt_dec[IW-1:0];
                        k_next     = cnt_dec;
                        state_next = L_SHUP;
                    end
                end else if (pos_inc >= count_reg) begin
                    count_next = cnt_dec;
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else begin
                    raddr      = pos_inc[IW-1:0];
                    k_next     = pos_inc;
                    state_next = L_SHDN;
                end
            end
            L_SHUP: begin
                we    = 1'b1;
                waddr = k_inc[IW-1:0];
                wdata = rdata_reg;
                if (k_reg == pos_reg) begin
                    state_next = L_PUT;
                end else begin
                    raddr  = k_dec[IW-1:0];
                    k_next = k_dec;
                end
            end
            L_SHDN: begin
                we    = 1'b1;
                waddr = k_dec[IW-1:0];
                wdata = rdata_reg;
                if (k_reg == cnt_dec) begin
                    count_next = cnt_dec;
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else begin
                    k_next = k_inc;
                end
            end
            L_PUT: begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    // List storage, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        hkey_reg  <= hkey_next;
        hslot_reg <= hslot_next;
    end

endmodule

/* sv/best_fit_heap_allocator.sv */
// Best-fit heap allocator for one heap of heap_size bytes at heap_base.
// Input channel (s_*): tuser is the request kind (0 allocate, 1 free);
// tdata carries the requested size and the address to free.
// Output channel (m_*): one transfer per request with the granted address
// and a status code; the address is zero on failure and on every free.
// Configuration: cfg_we/cfg_index/cfg_wdata write heap_base or heap_size;
// a heap_size write rebuilds the heap as one free block. Write only while
// no request is in flight.
// One request is processed at a time. Each of the free and used lists is
// one memory that is scanned and shifted one entry per cycle, so a request
// takes longer as the lists fill.
// Reset (synchronous, aresetn low) returns base 0 and size 65535 and then
// writes the initial descriptor, with s_tready low.
// A finished result waits in the output register while m_tready is low;
// a new request may be accepted meanwhile but its result waits behind it.
module best_fit_heap_allocator import bfha_pkg::*; #(
    parameter int DESCRIPTORS  = DEF_DESCRIPTORS,
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int USED_ENTRIES = DEF_USED_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [15:0] req_size, [47:16] address
    input  logic        s_tuser,    // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] block_address, [34:32] status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int SW  = $clog2(DESCRIPTORS);
    localparam int DW  = 32 + 2 * SW;
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int UCW = $clog2(USED_ENTRIES + 1);
    localparam int PREV_LSB = 32;
    localparam int NEXT_LSB = 32 + SW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AFIND  = 5'd1;
    localparam logic [4:0] S_ARDB   = 5'd2;
    localparam logic [4:0] S_AREMF  = 5'd3;
    localparam logic [4:0] S_AWB    = 5'd4;
    localparam logic [4:0] S_AINSF  = 5'd5;
    localparam logic [4:0] S_AINSU  = 5'd6;
    localparam logic [4:0] S_FFIND  = 5'd7;
    localparam logic [4:0] S_FRDF   = 5'd8;
    localparam logic [4:0] S_FREMU  = 5'd9;
    localparam logic [4:0] S_FFINDP = 5'd10;
    localparam logic [4:0] S_FREMP  = 5'd11;
    localparam logic [4:0] S_FRDP   = 5'd12;
    localparam logic [4:0] S_FNCHK  = 5'd13;
    localparam logic [4:0] S_FFINDN = 5'd14;
    localparam logic [4:0] S_FREMN  = 5'd15;
    localparam logic [4:0] S_FRDN   = 5'd16;
    localparam logic [4:0] S_FINS   = 5'd17;
    localparam logic [4:0] S_FINSW  = 5'd18;
    localparam logic [4:0] S_LINK   = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;

    // Descriptor memory: {next, prev, size, offset}.
    logic [DW-1:0] desc_mem [DESCRIPTORS];
    logic [DW-1:0] desc_rdata_reg;
    logic [DW-1:0] desc_wdata;
    logic [SW-1:0] desc_raddr, desc_waddr;
    logic          desc_we;

    logic [15:0]   rd_off, rd_size;
    logic [SW-1:0] rd_prev, rd_next;

    logic [4:0]    state_reg, state_next;
    logic          init_pending_reg, init_pending_next;
    logic [31:0]   heap_base_reg, heap_base_next;
    logic [15:0]   heap_size_reg, heap_size_next;
    logic [DESCRIPTORS-1:0] in_use_reg, in_use_next;
    logic [DESCRIPTORS-1:0] busy_reg, busy_next;

    logic [15:0]   sz_reg, sz_next;
    logic [15:0]   tgt_reg, tgt_next;
    logic [15:0]   rem_reg, rem_next;
    logic [SW-1:0] f_slot_reg, f_slot_next;
    logic [15:0]   f_off_reg, f_off_next;
    logic [15:0]   f_size_reg, f_size_next;
    logic [SW-1:0] f_prev_reg, f_prev_next;
    logic [SW-1:0] f_next_reg, f_next_next;
    logic [SW-1:0] ns_reg, ns_next;
    logic          pm_reg, pm_next;
    logic [SW-1:0] cur_slot_reg, cur_slot_next;
    logic [15:0]   cur_off_reg, cur_off_next;
    logic [15:0]   cur_size_reg, cur_size_next;
    logic [SW-1:0] cur_prev_reg, cur_prev_next;
    logic [SW-1:0] cur_next_reg, cur_next_next;
    logic [SW-1:0] link_slot_reg, link_slot_next;
    logic [SW-1:0] link_val_reg, link_val_next;
    logic [4:0]    ret_reg, ret_next;
    logic [FCW-1:0] fpos_reg, fpos_next;
    logic [UCW-1:0] upos_reg, upos_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_addr_reg, m_addr_next;
    logic [2:0]    m_status_reg, m_status_next;

    logic [31:0]   tgt_full;
    logic [15:0]   rem_calc, sum_calc;
    logic          pm_calc, nm_calc;
    logic [SW-1:0] idle_slot;
    logic          idle_found;

    list_cmd_t      fl_cmd, ul_cmd;
    logic [SW-1:0]  fl_slot, ul_slot;
    logic [FCW-1:0] fl_pos, fl_rpos;
    logic [UCW-1:0] ul_pos, ul_rpos;
    list_resp_t     fl_resp, ul_resp;
    logic [15:0]    fl_rkey, ul_rkey;
    logic [SW-1:0]  fl_rslot, ul_rslot;

    bfha_sorted_list #(.DEPTH(FREE_ENTRIES), .SW(SW)) u_free_list (
        .aclk(aclk), .aresetn(aresetn), .cmd(fl_cmd), .cmd_slot(fl_slot),
        .cmd_pos(fl_pos), .resp(fl_resp), .resp_pos(fl_rpos),
        .resp_key(fl_rkey), .resp_slot(fl_rslot)
    );

    bfha_sorted_list #(.DEPTH(USED_ENTRIES), .SW(SW)) u_used_list (
        .aclk(aclk), .aresetn(aresetn), .cmd(ul_cmd), .cmd_slot(ul_slot),
        .cmd_pos(ul_pos), .resp(ul_resp), .resp_pos(ul_rpos),
        .resp_key(ul_rkey), .resp_slot(ul_rslot)
    );

    assign rd_off  = desc_rdata_reg[15:0];
    assign rd_size = desc_rdata_reg[31:16];
    assign rd_prev = desc_rdata_reg[PREV_LSB +: SW];
    assign rd_next = desc_rdata_reg[NEXT_LSB +: SW];

    assign tgt_full = s_tdata[47:16] - heap_base_reg;
    assign rem_calc = rd_size - sz_reg;
    assign pm_calc  = (f_slot_reg != '0) && !in_use_reg[rd_prev];
    assign nm_calc  = (rd_next != '0) && !in_use_reg[rd_next];

    assign s_tready = (state_reg == S_IDLE) && !init_pending_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_addr_reg};

    // Lowest descriptor slot that holds no block.
    always_comb begin
        idle_found = 1'b0;
        idle_slot  = '0;
        for (int i = DESCRIPTORS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                idle_found = 1'b1;
                idle_slot  = SW'(i);
            end
        end
    end

    // Request sequencer.
    always_comb begin
        state_next        = state_reg;
        init_pending_next = init_pending_reg;
        heap_base_next    = heap_base_reg;
        heap_size_next    = heap_size_reg;
        in_use_next       = in_use_reg;
        busy_next         = busy_reg;
        sz_next           = sz_reg;
        tgt_next          = tgt_reg;
        rem_next          = rem_reg;
        f_slot_next       = f_slot_reg;
        f_off_next        = f_off_reg;
        f_size_next       = f_size_reg;
        f_prev_next       = f_prev_reg;
        f_next_next       = f_next_reg;
        ns_next           = ns_reg;
        pm_next           = pm_reg;
        cur_slot_next     = cur_slot_reg;
        cur_off_next      = cur_off_reg;
        cur_size_next     = cur_size_reg;
        cur_prev_next     = cur_prev_reg;
        cur_next_next     = cur_next_reg;
        link_slot_next    = link_slot_reg;
        link_val_next     = link_val_reg;
        ret_next          = ret_reg;
        fpos_next         = fpos_reg;
        upos_next         = upos_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_addr_next       = m_addr_reg;
        m_status_next     = m_status_reg;
        desc_we           = 1'b0;
        desc_waddr        = '0;
        desc_wdata        = '0;
        desc_raddr        = '0;
        fl_cmd            = '{op: LIST_NONE, key: 16'h0};
        fl_slot           = '0;
        fl_pos            = '0;
        ul_cmd            = '{op: LIST_NONE, key: 16'h0};
        ul_slot           = '0;
        ul_pos            = '0;
        sum_calc          = '0;

        case (state_reg)
            S_IDLE: begin
                if (init_pending_reg) begin
                    desc_we           = 1'b1;
                    desc_wdata        = {{(2 * SW){1'b0}}, heap_size_reg, 16'h0};
                    in_use_next       = '0;
                    busy_next         = DESCRIPTORS'(1);
                    fl_cmd            = '{op: LIST_INIT_ONE, key: heap_size_reg};
                    ul_cmd            = '{op: LIST_CLEAR, key: 16'h0};
                    init_pending_next = 1'b0;
                end else if (s_tvalid) begin
                    sz_next       = s_tdata[15:0];
                    res_addr_next = '0;
                    if (!s_tuser) begin
                        if (s_tdata[15:0] == 16'h0) begin
                            res_status_next = ST_ZERO_SIZE;
                            state_next      = S_DONE;
                        end else begin
                            fl_cmd     = '{op: LIST_FIND_KEY, key: s_tdata[15:0]};
                            state_next = S_AFIND;
                        end
                    end else if (tgt_full[31:16] != 16'h0) begin
                        res_status_next = ST_BAD_ADDR;
                        state_next      = S_DONE;
                    end else begin
                        tgt_next   = tgt_full[15:0];
                        ul_cmd     = '{op: LIST_FIND_KEY, key: tgt_full[15:0]};
                        state_next = S_FFIND;
                    end
                end
            end

            // Allocate: smallest fitting free block.
            S_AFIND: begin
                if (fl_resp.done) begin
                    if (!fl_resp.found) begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_DONE;
                    end else if (ul_resp.full) begin
                        res_status_next = ST_NO_SLOT;
                        state_next      = S_DONE;
                    end else begin
                        f_slot_next = fl_rslot;
                        fpos_next   = fl_rpos;
                        desc_raddr  = fl_rslot;
                        state_next  = S_ARDB;
                    end
                end
            end
            S_ARDB: begin
                f_off_next  = rd_off;
                f_size_next = rd_size;
                f_prev_next = rd_prev;
                f_next_next = rd_next;
                rem_next    = rem_calc;
                ns_next     = idle_slot;
                if (rem_calc != 16'h0 && !idle_found) begin
                    res_status_next = ST_NO_SLOT;
                    state_next      = S_DONE;
                end else begin
                    fl_cmd     = '{op: LIST_REMOVE, key: 16'h0};
                    fl_pos     = fpos_reg;
                    state_next = S_AREMF;
                end
            end
            S_AREMF: begin
                if (fl_resp.done) begin
                    if (rem_reg == 16'h0) begin
                        in_use_next[f_slot_reg] = 1'b1;
                        ul_cmd     = '{op: LIST_INSERT, key: f_off_reg};
                        ul_slot    = f_slot_reg;
                        state_next = S_AINSU;
                    end else begin
                        // Remainder block goes into the new slot.
                        desc_we    = 1'b1;
                        desc_waddr = ns_reg;
                        desc_wdata = {f_next_reg, f_slot_reg, rem_reg, f_off_reg + sz_reg};
                        busy_next[ns_reg] = 1'b1;
                        if (f_next_reg != '0) begin
                            desc_raddr     = f_next_reg;
                            link_slot_next = f_next_reg;
                            link_val_next  = ns_reg;
                            ret_next       = S_AWB;
                            state_next     = S_LINK;
                        end else begin
                            state_next = S_AWB;
                        end
                    end
                end
            end
            S_AWB: begin
                desc_we    = 1'b1;
                desc_waddr = f_slot_reg;
                desc_wdata = {ns_reg, f_prev_reg, sz_reg, f_off_reg};
                fl_cmd     = '{op: LIST_INSERT, key: rem_reg};
                fl_slot    = ns_reg;
                state_next = S_AINSF;
            end
            S_AINSF: begin
                if (fl_resp.done) begin
                    in_use_next[f_slot_reg] = 1'b1;
                    ul_cmd     = '{op: LIST_INSERT, key: f_off_reg};
                    ul_slot    = f_slot_reg;
                    state_next = S_AINSU;
                end
            end
            S_AINSU: begin
                if (ul_resp.done) begin
                    res_status_next = ST_OK;
                    res_addr_next   = heap_base_reg + {16'h0, f_off_reg};
                    state_next      = S_DONE;
                end
            end

            // Free: look up the block and merge with free neighbors.
            S_FFIND: begin
                if (ul_resp.done) begin
                    if (!ul_resp.found || ul_rkey != tgt_reg) begin
                        res_status_next = ST_BAD_ADDR;
                        state_next      = S_DONE;
                    end else begin
                        f_slot_next = ul_rslot;
                        upos_next   = ul_rpos;
                        desc_raddr  = ul_rslot;
                        state_next  = S_FRDF;
                    end
                end
            end
            S_FRDF: begin
                f_off_next  = rd_off;
                f_size_next = rd_size;
                f_prev_next = rd_prev;
                f_next_next = rd_next;
                pm_next     = pm_calc;
                if (!pm_calc && !nm_calc && fl_resp.full) begin
                    res_status_next = ST_NO_SLOT;
                    state_next      = S_DONE;
                end else begin
                    ul_cmd = '{op: LIST_REMOVE, key: 16'h0};
                    ul_pos = upos_reg;
                    in_use_next[f_slot_reg] = 1'b0;
                    state_next = S_FREMU;
                end
            end
            S_FREMU: begin
                if (ul_resp.done) begin
                    if (pm_reg) begin
                        fl_cmd     = '{op: LIST_FIND_SLOT, key: 16'h0};
                        fl_slot    = f_prev_reg;
                        state_next = S_FFINDP;
                    end else begin
                        cur_slot_next = f_slot_reg;
                        cur_off_next  = f_off_reg;
                        cur_size_next = f_size_reg;
                        cur_prev_next = f_prev_reg;
                        cur_next_next = f_next_reg;
                        state_next    = S_FNCHK;
                    end
                end
            end
            S_FFINDP: begin
                if (fl_resp.done) begin
                    if (fl_resp.found) begin
                        fl_cmd     = '{op: LIST_REMOVE, key: 16'h0};
                        fl_pos     = fl_rpos;
                        state_next = S_FREMP;
                    end else begin
                        desc_raddr = f_prev_reg;
                        state_next = S_FRDP;
                    end
                end
            end
            S_FREMP: begin
                if (fl_resp.done) begin
                    desc_raddr = f_prev_reg;
                    state_next = S_FRDP;
                end
            end
            S_FRDP: begin
                sum_calc      = rd_size + f_size_reg;
                cur_slot_next = f_prev_reg;
                cur_off_next  = rd_off;
                cur_size_next = sum_calc;
                cur_prev_next = rd_prev;
                cur_next_next = f_next_reg;
                desc_we       = 1'b1;
                desc_waddr    = f_prev_reg;
                desc_wdata    = {f_next_reg, rd_prev, sum_calc, rd_off};
                busy_next[f_slot_reg] = 1'b0;
                if (f_next_reg != '0) begin
                    desc_raddr     = f_next_reg;
                    link_slot_next = f_next_reg;
                    link_val_next  = f_prev_reg;
                    ret_next       = S_FNCHK;
                    state_next     = S_LINK;
                end else begin
                    state_next = S_FNCHK;
                end
            end
            S_FNCHK: begin
                if (cur_next_reg != '0 && !in_use_reg[cur_next_reg]) begin
                    fl_cmd     = '{op: LIST_FIND_SLOT, key: 16'h0};
                    fl_slot    = cur_next_reg;
                    state_next = S_FFINDN;
                end else begin
                    state_next = S_FINS;
                end
            end
            S_FFINDN: begin
                if (fl_resp.done) begin
                    if (fl_resp.found) begin
                        fl_cmd     = '{op: LIST_REMOVE, key: 16'h0};
                        fl_pos     = fl_rpos;
                        state_next = S_FREMN;
                    end else begin
                        desc_raddr = cur_next_reg;
                        state_next = S_FRDN;
                    end
                end
            end
            S_FREMN: begin
                if (fl_resp.done) begin
                    desc_raddr = cur_next_reg;
                    state_next = S_FRDN;
                end
            end
            S_FRDN: begin
                sum_calc      = cur_size_reg + rd_size;
                cur_size_next = sum_calc;
                cur_next_next = rd_next;
                desc_we       = 1'b1;
                desc_waddr    = cur_slot_reg;
                desc_wdata    = {rd_next, cur_prev_reg, sum_calc, cur_off_reg};
                busy_next[cur_next_reg] = 1'b0;
                if (rd_next != '0) begin
                    desc_raddr     = rd_next;
                    link_slot_next = rd_next;
                    link_val_next  = cur_slot_reg;
                    ret_next       = S_FINS;
                    state_next     = S_LINK;
                end else begin
                    state_next = S_FINS;
                end
            end
            S_FINS: begin
                fl_cmd     = '{op: LIST_INSERT, key: cur_size_reg};
                fl_slot    = cur_slot_reg;
                state_next = S_FINSW;
            end
            S_FINSW: begin
                if (fl_resp.done) begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            // Rewrite the prev link of a following block.
            S_LINK: begin
                desc_we    = 1'b1;
                desc_waddr = link_slot_reg;
                desc_wdata = desc_rdata_reg;
                desc_wdata[PREV_LSB +: SW] = link_val_reg;
                state_next = ret_reg;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Configuration writes.
        if (cfg_we) begin
            if (cfg_index == CFG_HEAP_BASE) begin
                heap_base_next = cfg_wdata;
            end else begin
                heap_size_next    = cfg_wdata[15:0];
                init_pending_next = 1'b1;
            end
        end
    end

    // Descriptor storage with registered read.
    always_ff @(posedge aclk) begin
        if (desc_we) begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
        desc_rdata_reg <= desc_mem[desc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            init_pending_reg <= 1'b1;
            heap_base_reg    <= '0;
            heap_size_reg    <= 16'hFFFF;
            in_use_reg       <= '0;
            busy_reg         <= DESCRIPTORS'(1);
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            init_pending_reg <= init_pending_next;
            heap_base_reg    <= heap_base_next;
            heap_size_reg    <= heap_size_next;
            in_use_reg       <= in_use_next;
            busy_reg         <= busy_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sz_reg         <= sz_next;
        tgt_reg        <= tgt_next;
        rem_reg        <= rem_next;
        f_slot_reg     <= f_slot_next;
        f_off_reg      <= f_off_next;
        f_size_reg     <= f_size_next;
        f_prev_reg     <= f_prev_next;
        f_next_reg     <= f_next_next;
        ns_reg         <= ns_next;
        pm_reg         <= pm_next;
        cur_slot_reg   <= cur_slot_next;
        cur_off_reg    <= cur_off_next;
        cur_size_reg   <= cur_size_next;
        cur_prev_reg   <= cur_prev_next;
        cur_next_reg   <= cur_next_next;
        link_slot_reg  <= link_slot_next;
        link_val_reg   <= link_val_next;
        ret_reg        <= ret_next;
        fpos_reg       <= fpos_next;
        upos_reg       <= upos_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

endmodule

/* sv/bfha_checker.sv */
`include "assert_macros.svh"

module bfha_checker import bfha_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Status codes stay within the defined set.
    `ASSERT_IMPLY(a_status_range, aclk, aresetn, m_tvalid, m_tdata[34:32] <= ST_BAD_ADDR)

    // Any failed request returns a zero address.
    `ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_tvalid && m_tdata[34:32] != ST_OK, m_tdata[31:0] == 32'h0)

    // Requests are processed one at a time.
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
